/* hdl/mexp_pkg.sv */
// mexp_pkg: shared types and defaults for the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int unsigned DefaultWordBits     = 64;
    localparam int unsigned DefaultExponentBits = 64;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_DOUBLE,
        MP_ADD
    } mul_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_WAIT,
        ST_STEP,
        ST_ACC_WAIT,
        ST_SQ_CHECK,
        ST_SQ_WAIT,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

/* hdl/modular_exponentiation_64.sv */
// modular_exponentiation_64: top level, square-and-multiply sequencer and result register
// depends on mexp_pkg and mexp_modmul
//
//  channel   signals                                         direction
//  item      item_valid, item_ready, base_value, power,      in
//            modulus_value
//  result    result_valid, result_ready, residue             out
//
// one modular multiply runs a double step per bit of y and an add step per set bit of y
// an item takes (1 + popcount(power) + bitlen(power) - 1) multiplies plus the
// sequencing states between them
// a modulus of 0 or 1 gives 0 without any multiply; reset is asynchronous, active low
// item_ready is high only while idle; a result still waiting holds the next one in finish
`timescale 1ns / 1ps

module modular_exponentiation_64 #(
    parameter int unsigned WORD_BITS     = mexp_pkg::DefaultWordBits,
    parameter int unsigned EXPONENT_BITS = mexp_pkg::DefaultExponentBits
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [WORD_BITS-1:0]     base_value,
    input  logic [EXPONENT_BITS-1:0] power,
    input  logic [WORD_BITS-1:0]     modulus_value,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [WORD_BITS-1:0]     residue
);
    import mexp_pkg::*;

    seq_state_t               state_reg, state_next;
    logic [WORD_BITS-1:0]     b_reg, b_next;
    logic [WORD_BITS-1:0]     m_reg, m_next;
    logic [WORD_BITS-1:0]     acc_reg, acc_next;
    logic [EXPONENT_BITS-1:0] e_reg, e_next;
    logic                     result_valid_reg, result_valid_next;
    logic [WORD_BITS-1:0]     residue_reg, residue_next;

    logic                     item_xfer;
    logic                     out_free;
    logic                     mul_start;
    logic [WORD_BITS-1:0]     mul_x;
    logic [WORD_BITS-1:0]     mul_y;
    mul_stat_t                mul_stat;
    logic [WORD_BITS-1:0]     mul_result;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;

    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (m_reg),
        .stat   (mul_stat),
        .result (mul_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = (modulus_value <= WORD_BITS'(1)) ? ST_FINISH : ST_RED_START;
                end
            end
            ST_RED_START:
            begin
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_ACC_WAIT;
                end
                else
                begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_ACC_WAIT:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK:
            begin
                state_next = ((e_reg >> 1) == '0) ? ST_FINISH : ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        b_next            = b_reg;
        m_next            = m_reg;
        acc_next          = acc_reg;
        e_next            = e_reg;
        residue_next      = residue_reg;
        result_valid_next = result_valid_reg && !result_ready;
        mul_start         = 1'b0;
        mul_x             = acc_reg;
        mul_y             = b_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    b_next   = base_value;
                    m_next   = modulus_value;
                    e_next   = power;
                    acc_next = '0;
                end
            end
            ST_RED_START:
            begin
                // base mod m as 1 * base mod m
                mul_start = 1'b1;
                mul_x     = WORD_BITS'(1);
                mul_y     = b_reg;
            end
            ST_RED_WAIT:
            begin
                if (mul_stat.done)
                begin
                    b_next   = mul_result;
                    acc_next = WORD_BITS'(1);
                end
            end
            ST_STEP:
            begin
                if (e_reg != '0 && e_reg[0])
                begin
                    mul_start = 1'b1;
                    mul_x     = acc_reg;
                    mul_y     = b_reg;
                end
            end
            ST_ACC_WAIT:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_result;
                end
            end
            ST_SQ_CHECK:
            begin
                e_next = e_reg >> 1;
                if ((e_reg >> 1) != '0)
                begin
                    mul_start = 1'b1;
                    mul_x     = b_reg;
                    mul_y     = b_reg;
                end
            end
            ST_SQ_WAIT:
            begin
                if (mul_stat.done)
                begin
                    b_next = mul_result;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    residue_next      = acc_reg;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        m_reg       <= m_next;
        acc_reg     <= acc_next;
        e_reg       <= e_next;
        residue_reg <= residue_next;
    end

    assign result_valid = result_valid_reg;
    assign residue      = residue_reg;

endmodule

/* hdl/mexp_modmul.sv */
// mexp_modmul: shared modular multiplier, one modular add per cycle (double-and-add)
// depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_modmul #(
    parameter int unsigned WORD_BITS = mexp_pkg::DefaultWordBits
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_BITS-1:0]  x,
    input  logic [WORD_BITS-1:0]  y,
    input  logic [WORD_BITS-1:0]  m,
    output mexp_pkg::mul_stat_t   stat,
    output logic [WORD_BITS-1:0]  result
);
    import mexp_pkg::*;

    localparam int unsigned CntW = $clog2(WORD_BITS);

    mul_phase_t           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] m_reg, m_next;

    logic [WORD_BITS-1:0] addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_red;
    logic                 last_bit;

    // single modular add: r + addend mod m
    always_comb
    begin
        addend  = (phase_reg == MP_ADD) ? x_reg : r_reg;
        sum     = {1'b0, r_reg} + {1'b0, addend};
        sum_red = (sum >= {1'b0, m_reg}) ? (sum - {1'b0, m_reg}) : sum;
    end

    assign last_bit = (cnt_reg == '0);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE:
            begin
                if (start)
                begin
                    phase_next = MP_DOUBLE;
                end
            end
            MP_DOUBLE:
            begin
                if (y_reg[WORD_BITS-1])
                begin
                    phase_next = MP_ADD;
                end
                else if (last_bit)
                begin
                    phase_next = MP_IDLE;
                end
            end
            MP_ADD:
            begin
                phase_next = last_bit ? MP_IDLE : MP_DOUBLE;
            end
            default:
            begin
                phase_next = MP_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        unique case (phase_reg)
            MP_IDLE:
            begin
                if (start)
                begin
                    r_next   = '0;
                    x_next   = x;
                    y_next   = y;
                    m_next   = m;
                    cnt_next = CntW'(WORD_BITS - 1);
                end
            end
            MP_DOUBLE:
            begin
                r_next = sum_red[WORD_BITS-1:0];
                if (!y_reg[WORD_BITS-1])
                begin
                    y_next    = y_reg << 1;
                    cnt_next  = cnt_reg - CntW'(1);
                    done_next = last_bit;
                end
            end
            MP_ADD:
            begin
                r_next    = sum_red[WORD_BITS-1:0];
                y_next    = y_reg << 1;
                cnt_next  = cnt_reg - CntW'(1);
                done_next = last_bit;
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = (phase_reg != MP_IDLE);
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule
